>>> sv/sprite_vm_instruction_core_assert.svh
// Assertion helpers for the VM core.
`ifndef SPRITE_VM_INSTRUCTION_CORE_ASSERT_SVH
`define SPRITE_VM_INSTRUCTION_CORE_ASSERT_SVH

// Same-cycle implication.
`define SVIC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SVIC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/svic_pkg.sv
`default_nettype none
package svic_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;

  localparam logic [11:0] START_PC   = 12'h200;
  localparam logic [11:0] FONT_BASE  = 12'h050;
  localparam logic [11:0] FONT_END   = 12'h0A0;
  localparam logic [11:0] ADDR_MAX   = 12'hFFF;
  localparam logic [4:0]  STACK_FULL = 5'd16;

  // operation codes
  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_ROW   = 2'd3;

  // full opcodes and FxNN / ExNN selectors
  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;
  localparam logic [7:0]  FN_KEY_DOWN = 8'h9E;
  localparam logic [7:0]  FN_KEY_UP   = 8'hA1;
  localparam logic [7:0]  FN_GET_DT   = 8'h07;
  localparam logic [7:0]  FN_SET_DT   = 8'h15;
  localparam logic [7:0]  FN_SET_ST   = 8'h18;
  localparam logic [7:0]  FN_ADD_I    = 8'h1E;
  localparam logic [7:0]  FN_FONT     = 8'h29;
  localparam logic [7:0]  FN_BCD      = 8'h33;
  localparam logic [7:0]  FN_SAVE     = 8'h55;
  localparam logic [7:0]  FN_LOAD     = 8'h65;

  localparam logic [7:0] FONT_ROM [0:79] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [15:0] keys;
    logic [7:0]  random_byte;
  } cmd_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] last_opcode;
    logic [63:0] display_row;
    logic        sound_active;
    logic        display_changed;
    logic        fault;
  } rsp_t;

  // register file access for one cycle
  typedef struct packed {
    logic       we;
    logic [3:0] waddr;
    logic [7:0] wdata;
    logic [3:0] ra;
    logic [3:0] rb;
  } reg_req_t;

endpackage
`default_nettype wire

>>> sv/svic_regs.sv
`default_nettype none
module svic_regs
  import svic_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire reg_req_t   req,
  output logic [7:0]      rdata_a,
  output logic [7:0]      rdata_b
);

  logic [7:0]  rf [16];
  logic [15:0] valid;
  logic [7:0]  qa, qb;
  logic        va, vb;

  always_ff @(posedge clk) begin
    if (req.we) begin
      rf[req.waddr] <= req.wdata;
    end
    qa <= rf[req.ra];
    qb <= rf[req.rb];
  end

  // unwritten registers read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      va    <= 1'b0;
      vb    <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      va <= valid[req.ra];
      vb <= valid[req.rb];
    end
  end

  assign rdata_a = va ? qa : 8'd0;
  assign rdata_b = vb ? qb : 8'd0;

endmodule
`default_nettype wire

>>> sv/sprite_vm_instruction_core.sv
// 8xy4..8xy7, 8xyE, Dxyn, Fx33, Fx55 and Fx65 run extra sequencer states after execute.
// Throughput: one item at a time; the main memory sequencer sets it.
// Reset: a clearing pass loads zeros and the font into main memory;
// cmd_stall stays high until it ends. Registers and display reset via valid bits.
`default_nettype none
`include "sprite_vm_instruction_core_assert.svh"
module sprite_vm_instruction_core
  import svic_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // sequencer states
  localparam logic [4:0] ST_CLEAR      = 5'd0;
  localparam logic [4:0] ST_IDLE       = 5'd1;
  localparam logic [4:0] ST_FETCH_LO   = 5'd2;  // high byte back, ask for low byte
  localparam logic [4:0] ST_FETCH_WAIT = 5'd3;  // low byte back, read Vx / Vy
  localparam logic [4:0] ST_EXEC       = 5'd4;
  localparam logic [4:0] ST_WR_RES     = 5'd5;  // ALU result after VF
  localparam logic [4:0] ST_DRAW_RD    = 5'd6;
  localparam logic [4:0] ST_DRAW_WR    = 5'd7;
  localparam logic [4:0] ST_DRAW_FLAG  = 5'd8;
  localparam logic [4:0] ST_BCD        = 5'd9;
  localparam logic [4:0] ST_SAVE_RD    = 5'd10;
  localparam logic [4:0] ST_SAVE_WR    = 5'd11;
  localparam logic [4:0] ST_LOAD_RD    = 5'd12;
  localparam logic [4:0] ST_LOAD_WR    = 5'd13;
  localparam logic [4:0] ST_ROW_WAIT   = 5'd14;
  localparam logic [4:0] ST_DONE       = 5'd15;

  logic [4:0]  state;
  logic [11:0] clr_cnt;
  cmd_t        cmd_r;
  logic        cmd_fire;

  // architectural state
  logic [11:0] pc;
  logic [11:0] index_reg;
  logic [4:0]  depth;
  logic [7:0]  delay_count, sound_count;
  logic [15:0] opcode_reg;
  logic [11:0] stack_mem [16];

  // per-beat scratch
  logic [7:0]  opc_hi;
  logic        changed_r, fault_r, row_ok;
  logic [63:0] row_r;
  logic [7:0]  res_r, val_r;
  logic [3:0]  cnt;
  logic [5:0]  xp;
  logic [4:0]  yp;
  logic        coll;

  rsp_t        rsp_r;
  logic        rsp_valid_r;

  // main memory, one port each way, registered read
  logic [7:0]  main_mem [MEM_BYTES];
  logic [11:0] mem_raddr, mem_waddr;
  logic [7:0]  mem_wdata, mem_q;
  logic        mem_we;

  // display rows
  logic [63:0] frame_mem [SCREEN_HEIGHT];
  logic [31:0] frame_valid;
  logic [4:0]  frame_raddr, frame_waddr;
  logic [63:0] frame_wdata, frame_q, frame_old;
  logic        frame_we, frame_vq, frame_clr;

  reg_req_t    rreq;
  logic [7:0]  rx, ry;

  // decoded fields
  logic [3:0]  nib, ox, oy, on;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [15:0] opc_w;

  assign nib = opcode_reg[15:12];
  assign ox  = opcode_reg[11:8];
  assign oy  = opcode_reg[7:4];
  assign on  = opcode_reg[3:0];
  assign nn  = opcode_reg[7:0];
  assign nnn = opcode_reg[11:0];
  assign opc_w = {opc_hi, mem_q};

  assign cmd_stall = (state != ST_IDLE);
  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign rsp_valid = rsp_valid_r;
  assign rsp       = rsp_r;

  svic_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .req     (rreq),
    .rdata_a (rx),
    .rdata_b (ry)
  );

  // ALU: VF lands first, then subtract and shift results see the new VF when x or y is F
  logic       alu_fe, alu_we, alu_flag;
  logic [7:0] alu_res, rxf, ryf;
  logic [8:0] alu_sum;

  always_comb begin
    alu_fe   = 1'b0;
    alu_we   = 1'b0;
    alu_flag = 1'b0;
    alu_res  = 8'd0;
    alu_sum  = {1'b0, rx} + {1'b0, ry};
    unique case (on)
      4'h5:    alu_flag = (rx > ry);
      4'h6:    alu_flag = rx[0];
      4'h7:    alu_flag = (ry > rx);
      4'hE:    alu_flag = rx[7];
      default: alu_flag = alu_sum[8];
    endcase
    rxf = (ox == 4'hF) ? {7'd0, alu_flag} : rx;
    ryf = (oy == 4'hF) ? {7'd0, alu_flag} : ry;
    unique case (on)
      4'h0: begin alu_we = 1'b1; alu_res = ry; end
      4'h1: begin alu_we = 1'b1; alu_res = rx | ry; end
      4'h2: begin alu_we = 1'b1; alu_res = rx & ry; end
      4'h3: begin alu_we = 1'b1; alu_res = rx ^ ry; end
      4'h4: begin alu_fe = 1'b1; alu_res = alu_sum[7:0]; end
      4'h5: begin alu_fe = 1'b1; alu_res = rxf - ryf; end
      4'h6: begin alu_fe = 1'b1; alu_res = rxf >> 1; end
      4'h7: begin alu_fe = 1'b1; alu_res = ryf - rxf; end
      4'hE: begin alu_fe = 1'b1; alu_res = rxf << 1; end
      default: ;
    endcase
  end

  // where the sequencer goes after the execute cycle
  logic [4:0] exec_next;

  always_comb begin
    exec_next = ST_DONE;
    unique case (nib)
      4'h8: if (alu_fe) exec_next = ST_WR_RES;
      4'hD: exec_next = (on == 4'd0) ? ST_DRAW_FLAG : ST_DRAW_RD;
      4'hF: begin
        unique case (nn)
          FN_BCD:  exec_next = ST_BCD;
          FN_SAVE: exec_next = ST_SAVE_RD;
          FN_LOAD: exec_next = ST_LOAD_RD;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // BCD digits of the latched register value
  logic [1:0]  bcd_h;
  logic [7:0]  bcd_rem;
  logic [14:0] bcd_prod;
  logic [3:0]  bcd_t;
  logic [6:0]  bcd_o;
  logic [7:0]  bcd_digit;

  always_comb begin
    priority if (val_r >= 8'd200) bcd_h = 2'd2;
    else if (val_r >= 8'd100)     bcd_h = 2'd1;
    else                          bcd_h = 2'd0;
    bcd_rem  = val_r - ((bcd_h == 2'd2) ? 8'd200 : (bcd_h == 2'd1) ? 8'd100 : 8'd0);
    // x/10 as x*205 >> 11, exact below 1029
    bcd_prod = {8'd0, bcd_rem[6:0]} * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = bcd_rem[6:0] - ({3'd0, bcd_t} * 7'd10);
    unique case (cnt[1:0])
      2'd0:    bcd_digit = {6'd0, bcd_h};
      2'd1:    bcd_digit = {4'd0, bcd_t};
      default: bcd_digit = {4'd0, bcd_o[3:0]};
    endcase
  end

  // sprite row placed at column xp, wrapping
  logic [63:0]  spr_row, spr_mask;
  logic [127:0] spr_dbl;
  logic [11:0]  font_off;

  always_comb begin
    spr_row   = {mem_q, 56'd0};
    spr_dbl   = {spr_row, spr_row} >> xp;
    spr_mask  = spr_dbl[63:0];
    frame_old = frame_vq ? frame_q : 64'd0;
    font_off  = clr_cnt - FONT_BASE;
  end

  // memory port steering
  always_comb begin
    mem_raddr = pc;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = 8'd0;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt >= FONT_BASE && clr_cnt < FONT_END) begin
          mem_wdata = FONT_ROM[font_off[6:0]];
        end
      end
      ST_IDLE: begin
        if (cmd_fire && cmd.operation == OP_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = cmd.address;
          mem_wdata = cmd.write_data;
        end
      end
      ST_FETCH_LO: mem_raddr = pc + 12'd1;
      ST_DRAW_RD:  mem_raddr = index_reg + {8'd0, cnt};
      ST_LOAD_RD:  mem_raddr = index_reg + {8'd0, cnt};
      ST_BCD: begin
        mem_we    = 1'b1;
        mem_waddr = index_reg + {8'd0, cnt};
        mem_wdata = bcd_digit;
      end
      ST_SAVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = index_reg + {8'd0, cnt};
        mem_wdata = rx;
      end
      default: ;
    endcase
  end

  // register file and display port steering
  always_comb begin
    rreq        = '0;
    frame_raddr = yp + {1'b0, cnt};
    frame_we    = 1'b0;
    frame_waddr = yp + {1'b0, cnt};
    frame_wdata = frame_old ^ spr_mask;
    frame_clr   = 1'b0;
    unique case (state)
      ST_IDLE: frame_raddr = cmd.address[4:0];
      ST_FETCH_WAIT: begin
        rreq.ra = (opc_w[15:12] == 4'hB) ? 4'h0 : opc_w[11:8];
        rreq.rb = opc_w[7:4];
      end
      ST_EXEC: begin
        unique case (nib)
          4'h0: frame_clr = (opcode_reg == OPC_CLS);
          4'h6: begin rreq.we = 1'b1; rreq.waddr = ox; rreq.wdata = nn; end
          4'h7: begin rreq.we = 1'b1; rreq.waddr = ox; rreq.wdata = rx + nn; end
          4'h8: begin
            if (alu_fe) begin
              rreq.we = 1'b1; rreq.waddr = 4'hF; rreq.wdata = {7'd0, alu_flag};
            end else if (alu_we) begin
              rreq.we = 1'b1; rreq.waddr = ox; rreq.wdata = alu_res;
            end
          end
          4'hC: begin
            rreq.we = 1'b1; rreq.waddr = ox; rreq.wdata = cmd_r.random_byte & nn;
          end
          4'hF: begin
            if (nn == FN_GET_DT) begin
              rreq.we = 1'b1; rreq.waddr = ox; rreq.wdata = delay_count;
            end
          end
          default: ;
        endcase
      end
      ST_WR_RES: begin rreq.we = 1'b1; rreq.waddr = ox; rreq.wdata = res_r; end
      ST_DRAW_WR: frame_we = 1'b1;
      ST_DRAW_FLAG: begin rreq.we = 1'b1; rreq.waddr = 4'hF; rreq.wdata = {7'd0, coll}; end
      ST_SAVE_RD: rreq.ra = cnt;
      ST_LOAD_WR: begin rreq.we = 1'b1; rreq.waddr = cnt; rreq.wdata = mem_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      main_mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= main_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[frame_waddr] <= frame_wdata;
    end
    frame_q <= frame_mem[frame_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      frame_vq    <= 1'b0;
    end else begin
      if (frame_clr) begin
        frame_valid <= '0;
      end else if (frame_we) begin
        frame_valid[frame_waddr] <= 1'b1;
      end
      frame_vq <= frame_valid[frame_raddr];
    end
  end

  logic key_hit;
  assign key_hit = (rx[7:4] == 4'd0) && cmd_r.keys[rx[3:0]];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= 12'd0;
      pc          <= START_PC;
      index_reg   <= 12'd0;
      depth       <= 5'd0;
      delay_count <= 8'd0;
      sound_count <= 8'd0;
      opcode_reg  <= 16'd0;
      rsp_valid_r <= 1'b0;
    end else begin
      // ST_DONE reloads the output register itself
      if (rsp_valid_r && !rsp_stall && state != ST_DONE) begin
        rsp_valid_r <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 12'd1;
          if (clr_cnt == ADDR_MAX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_fire) begin
            cmd_r     <= cmd;
            changed_r <= 1'b0;
            fault_r   <= 1'b0;
            row_r     <= 64'd0;
            row_ok    <= (cmd.address[11:5] == 7'd0);
            unique case (cmd.operation)
              OP_EXEC: state <= ST_FETCH_LO;
              OP_TICK: begin
                if (delay_count != 8'd0) delay_count <= delay_count - 8'd1;
                if (sound_count != 8'd0) sound_count <= sound_count - 8'd1;
                state <= ST_DONE;
              end
              OP_WRITE: state <= ST_DONE;
              default:  state <= ST_ROW_WAIT;
            endcase
          end
        end
        ST_FETCH_LO: begin
          opc_hi <= mem_q;
          state  <= ST_FETCH_WAIT;
        end
        ST_FETCH_WAIT: begin
          opcode_reg <= opc_w;
          pc         <= pc + 12'd2;
          state      <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= exec_next;
          res_r <= alu_res;
          val_r <= rx;
          cnt   <= 4'd0;
          unique case (nib)
            4'h0: begin
              if (opcode_reg == OPC_CLS) begin
                changed_r <= 1'b1;
              end else if (opcode_reg == OPC_RET) begin
                if (depth == 5'd0) begin
                  fault_r <= 1'b1;
                end else begin
                  depth <= depth - 5'd1;
                  pc    <= stack_mem[depth[3:0] - 4'd1];
                end
              end
            end
            4'h1: pc <= nnn;
            4'h2: begin
              if (depth >= STACK_FULL) begin
                fault_r <= 1'b1;
              end else begin
                stack_mem[depth[3:0]] <= pc;
                depth <= depth + 5'd1;
                pc    <= nnn;
              end
            end
            4'h3: if (rx == nn) pc <= pc + 12'd2;
            4'h4: if (rx != nn) pc <= pc + 12'd2;
            4'h5: if (rx == ry) pc <= pc + 12'd2;
            4'h9: if (rx != ry) pc <= pc + 12'd2;
            4'hA: index_reg <= nnn;
            4'hB: pc <= nnn + {4'd0, rx};
            4'hD: begin
              changed_r <= 1'b1;
              xp        <= rx[5:0];
              yp        <= ry[4:0];
              coll      <= 1'b0;
            end
            4'hE: begin
              if (nn == FN_KEY_DOWN && key_hit) pc <= pc + 12'd2;
              if (nn == FN_KEY_UP && !key_hit)  pc <= pc + 12'd2;
            end
            4'hF: begin
              unique case (nn)
                FN_SET_DT: delay_count <= rx;
                FN_SET_ST: sound_count <= rx;
                FN_ADD_I:  index_reg <= index_reg + {4'd0, rx};
                FN_FONT:   index_reg <= FONT_BASE + {2'd0, rx, 2'd0} + {4'd0, rx};
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        ST_WR_RES: state <= ST_DONE;
        ST_DRAW_RD: state <= ST_DRAW_WR;
        ST_DRAW_WR: begin
          if ((frame_old & spr_mask) != 64'd0) coll <= 1'b1;
          cnt <= cnt + 4'd1;
          state <= (cnt == on - 4'd1) ? ST_DRAW_FLAG : ST_DRAW_RD;
        end
        ST_DRAW_FLAG: state <= ST_DONE;
        ST_BCD: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd2) state <= ST_DONE;
        end
        ST_SAVE_RD: state <= ST_SAVE_WR;
        ST_SAVE_WR: begin
          cnt   <= cnt + 4'd1;
          state <= (cnt == ox) ? ST_DONE : ST_SAVE_RD;
        end
        ST_LOAD_RD: state <= ST_LOAD_WR;
        ST_LOAD_WR: begin
          cnt   <= cnt + 4'd1;
          state <= (cnt == ox) ? ST_DONE : ST_LOAD_RD;
        end
        ST_ROW_WAIT: begin
          if (row_ok) row_r <= frame_old;
          state <= ST_DONE;
        end
        ST_DONE: begin
          // output register frees the input side once loaded
          if (!rsp_valid_r || !rsp_stall) begin
            rsp_r.program_counter <= pc;
            rsp_r.last_opcode     <= opcode_reg;
            rsp_r.display_row     <= row_r;
            rsp_r.sound_active    <= (sound_count != 8'd0);
            rsp_r.display_changed <= changed_r;
            rsp_r.fault           <= fault_r;
            rsp_valid_r           <= 1'b1;
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SVIC_ASSERT_NXT(a_fire_busy, cmd_fire, state != ST_IDLE, "accepted beat left sequencer idle")
  `SVIC_ASSERT_IMP(a_draw_rows, state == ST_DRAW_WR, cnt < on, "sprite row past height")
  `SVIC_ASSERT_IMP(a_depth, 1'b1, depth <= STACK_FULL, "return stack depth overrun")
  `SVIC_ASSERT_IMP(a_fault_op, rsp_valid_r && rsp_r.fault, rsp_r.last_opcode[15:12] == 4'h0 || rsp_r.last_opcode[15:12] == 4'h2, "fault from non-stack op")
  `SVIC_ASSERT_IMP(a_clear_quiet, state == ST_CLEAR, !rsp_valid_r, "response during clear pass")

endmodule
`default_nettype wire
